FILE: sv/mts_pkg.sv
// mts_pkg: shared types and codes for the min-tracking stack.
// Operation and status codes, controller-to-datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_POP_EMPTY = 2'd1,
        STATUS_PUSH_FULL = 2'd2
    } mts_status_t;

    typedef struct packed {
        logic latch;       // capture operands of an accepted transaction
        logic exec;        // push, or a rejected pop, completes this cycle
        logic pop_read;    // issue the value-top and next-minimum reads for a pop
        logic pop_finish;  // read data valid, retire the pop
    } mts_cmd_t;

    typedef struct packed {
        logic op_pop;
        logic empty;
    } mts_stat_t;

endpackage

`default_nettype wire

FILE: sv/mts_ram.sv
// mts_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/mts_ctrl.sv
// mts_ctrl: transaction sequencer for the min-tracking stack.
// Depends on mts_pkg for command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl
    import mts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire mts_stat_t stat,
    output logic           busy,
    output mts_cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.op_pop && !stat.empty)
                begin
                    cmd.pop_read = 1'b1;
                    state_next   = S_WAIT;
                end
                else
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_WAIT:
            begin
                cmd.pop_finish = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire

FILE: sv/mts_datapath.sv
// mts_datapath: value and minimum stacks, counters and result registers.
// Depends on mts_pkg and mts_ram.
`timescale 1ns / 1ps
`default_nettype none

module mts_datapath
    import mts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire mts_cmd_t                   cmd,
    input  wire logic                       op,
    input  wire logic signed [WIDTH-1:0]    push_value,
    output mts_stat_t                       stat,
    output logic                            done,
    output logic signed [WIDTH-1:0]         popped_value,
    output logic signed [WIDTH-1:0]         current_min,
    output logic                            is_empty,
    output logic [$clog2(DEPTH+1)-1:0]      entry_count,
    output logic [1:0]                      status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [WIDTH-1:0] INT_MAX = {1'b0, {(WIDTH-1){1'b1}}};

    logic                    op_reg;
    logic [WIDTH-1:0]        val_reg;
    logic [CW-1:0]           vcnt_reg, vcnt_next;
    logic [CW-1:0]           mcnt_reg, mcnt_next;
    logic [WIDTH-1:0]        mtop_reg, mtop_next;
    logic                    done_reg;
    logic [WIDTH-1:0]        popped_reg, popped_next;
    logic [WIDTH-1:0]        min_reg;
    logic                    empty_reg;
    logic [CW-1:0]           count_reg;
    mts_status_t             status_reg, status_next;

    logic                    full;
    logic                    min_push;
    logic                    vram_we, mram_we;
    logic [WIDTH-1:0]        vram_rdata, mram_rdata;
    logic [AW-1:0]           vram_raddr, mram_raddr;
    logic [CW-1:0]           vcnt_dec, mcnt_dec2;

    assign full      = (vcnt_reg == FULL_COUNT);
    assign min_push  = (mcnt_reg != FULL_COUNT) &&
                       ((mcnt_reg == '0) || ($signed(val_reg) <= $signed(mtop_reg)));
    assign vram_we   = cmd.exec && (op_reg == OP_PUSH) && !full;
    assign mram_we   = vram_we && min_push;
    assign vcnt_dec  = vcnt_reg - CW'(1);
    assign mcnt_dec2 = mcnt_reg - CW'(2);
    assign vram_raddr = vcnt_dec[AW-1:0];
    assign mram_raddr = mcnt_dec2[AW-1:0];

    mts_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_value_ram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vcnt_reg[AW-1:0]),
        .wdata (val_reg),
        .re    (cmd.pop_read),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    mts_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_min_ram (
        .clk   (clk),
        .we    (mram_we),
        .waddr (mcnt_reg[AW-1:0]),
        .wdata (val_reg),
        .re    (cmd.pop_read),
        .raddr (mram_raddr),
        .rdata (mram_rdata)
    );

    always_comb
    begin
        vcnt_next   = vcnt_reg;
        mcnt_next   = mcnt_reg;
        mtop_next   = mtop_reg;
        popped_next = '0;
        status_next = STATUS_OK;
        if (cmd.exec)
        begin
            if (op_reg == OP_POP)
            begin
                status_next = STATUS_POP_EMPTY;
            end
            else if (full)
            begin
                status_next = STATUS_PUSH_FULL;
            end
            else
            begin
                vcnt_next = vcnt_reg + CW'(1);
                if (min_push)
                begin
                    mcnt_next = mcnt_reg + CW'(1);
                    mtop_next = val_reg;
                end
            end
        end
        else if (cmd.pop_finish)
        begin
            vcnt_next   = vcnt_dec;
            popped_next = vram_rdata;
            if ((mcnt_reg != '0) && (mtop_reg == vram_rdata))
            begin
                mcnt_next = mcnt_reg - CW'(1);
                mtop_next = mram_rdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= '0;
            mcnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vcnt_reg <= vcnt_next;
            mcnt_reg <= mcnt_next;
            done_reg <= cmd.exec || cmd.pop_finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= op;
            val_reg <= push_value;
        end
        mtop_reg <= mtop_next;
        if (cmd.exec || cmd.pop_finish)
        begin
            popped_reg <= popped_next;
            min_reg    <= (mcnt_next == '0) ? INT_MAX : mtop_next;
            empty_reg  <= (vcnt_next == '0);
            count_reg  <= vcnt_next;
            status_reg <= status_next;
        end
    end

    assign stat.op_pop  = (op_reg == OP_POP);
    assign stat.empty   = (vcnt_reg == '0);
    assign done         = done_reg;
    assign popped_value = popped_reg;
    assign current_min  = min_reg;
    assign is_empty     = empty_reg;
    assign entry_count  = count_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

FILE: sv/min_tracking_stack.sv
// min_tracking_stack: top level of the LIFO stack with running minimum.
// Depends on mts_pkg, mts_ctrl, mts_datapath (and mts_ram below it).
//
// Usage:
//   Command channel: a transaction is accepted at a rising edge with start high
//   and busy low. op selects push (0) or pop (1); push_value is the word to push.
//   Result channel: done is high for exactly one cycle with popped_value,
//   current_min, is_empty, entry_count and status. The receiver cannot stall.
//   Sequence: a push, or a pop on an empty stack, is retired in the execute
//   state; a pop with data is retired in the wait state that follows, after the
//   registered read port of the value and minimum RAMs. busy is high from
//   acceptance until done is shown, so a new command can be accepted while done
//   is high, and not before the previous result is shown.
//   A push on a full stack reports status 2 and drops the word; a pop on an
//   empty stack reports status 1. current_min reads the largest positive value
//   when the stack is empty.
//   Reset (rst_n low, asynchronous) empties both stacks and clears busy and
//   done; RAM contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       op,
    input  wire logic signed [WIDTH-1:0]    push_value,
    output logic                            done,
    output logic signed [WIDTH-1:0]         popped_value,
    output logic signed [WIDTH-1:0]         current_min,
    output logic                            is_empty,
    output logic [$clog2(DEPTH+1)-1:0]      entry_count,
    output logic [1:0]                      status
);

    mts_cmd_t  cmd;
    mts_stat_t stat;

    mts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (cmd)
    );

    mts_datapath #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .op           (op),
        .push_value   (push_value),
        .stat         (stat),
        .done         (done),
        .popped_value (popped_value),
        .current_min  (current_min),
        .is_empty     (is_empty),
        .entry_count  (entry_count),
        .status       (status)
    );

endmodule

`default_nettype wire

FILE: sv/mts_checker.sv
// mts_checker: port-level assertions for min_tracking_stack, bound to the top.
// Depends on mts_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module mts_checker
    import mts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        done,
    input wire logic signed [WIDTH-1:0]     popped_value,
    input wire logic signed [WIDTH-1:0]     current_min,
    input wire logic                        is_empty,
    input wire logic [$clog2(DEPTH+1)-1:0]  entry_count,
    input wire logic [1:0]                  status
);

    localparam logic [WIDTH-1:0] INT_MAX = {1'b0, {(WIDTH-1){1'b1}}};

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (entry_count == '0)))
        else $error("is_empty disagrees with entry_count");

    a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_empty) |-> (current_min == INT_MAX))
        else $error("empty stack minimum not largest positive value");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |-> (popped_value == '0))
        else $error("rejected transaction returned a popped value");

endmodule

bind min_tracking_stack mts_checker #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_mts_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .popped_value (popped_value),
    .current_min  (current_min),
    .is_empty     (is_empty),
    .entry_count  (entry_count),
    .status       (status)
);

`default_nettype wire

FILE: dv/min_tracking_stack_checker.sv
// min_tracking_stack_checker: predicts each command of the min-tracking stack and
// compares every done strobe with the oldest prediction. Depends on mts_pkg.
`timescale 1ns / 1ps

module min_tracking_stack_checker
    import mts_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic                       op,
    input  wire logic signed [WIDTH-1:0]    push_value,
    input  wire logic                       done,
    input  wire logic signed [WIDTH-1:0]    popped_value,
    input  wire logic signed [WIDTH-1:0]    current_min,
    input  wire logic                       is_empty,
    input  wire logic [$clog2(DEPTH+1)-1:0] entry_count,
    input  wire logic [1:0]                 status,
    output int                              fail_count,
    output int                              pending
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic signed [WIDTH-1:0] LARGEST = {1'b0, {(WIDTH-1){1'b1}}};

    typedef struct {
        logic signed [WIDTH-1:0] popped;
        logic signed [WIDTH-1:0] minimum;
        logic                    empty;
        logic [CW-1:0]           count;
        mts_status_t             code;
    } stack_result_t;

    logic signed [WIDTH-1:0] value_mem [DEPTH];
    logic signed [WIDTH-1:0] min_mem [DEPTH];
    int                      value_depth;
    int                      min_depth;
    stack_result_t           expected_q [$];

    function automatic stack_result_t step_stack(input logic o,
                                                 input logic signed [WIDTH-1:0] v);
        stack_result_t r;
        r.popped = '0;
        r.code   = STATUS_OK;
        if (o == OP_PUSH)
        begin
            if (value_depth >= DEPTH)
                r.code = STATUS_PUSH_FULL;
            else
            begin
                value_mem[value_depth] = v;
                value_depth++;
                // ties go onto the min stack so duplicates of the minimum survive pops
                if (min_depth < DEPTH && (min_depth == 0 || v <= min_mem[min_depth-1]))
                begin
                    min_mem[min_depth] = v;
                    min_depth++;
                end
            end
        end
        else
        begin
            if (value_depth == 0)
                r.code = STATUS_POP_EMPTY;
            else
            begin
                value_depth--;
                r.popped = value_mem[value_depth];
                if (min_depth > 0 && min_mem[min_depth-1] == r.popped)
                    min_depth--;
            end
        end
        r.minimum = (min_depth == 0) ? LARGEST : min_mem[min_depth-1];
        r.empty   = (value_depth == 0);
        r.count   = CW'(value_depth);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want;
        if (!rst_n)
        begin
            value_depth = 0;
            min_depth   = 0;
            fail_count  = 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction, popped %0d min %0d",
                             $time, popped_value, current_min);
                    fail_count++;
                end
                else
                begin
                    want = expected_q[0];
                    expected_q.delete(0);
                    if (popped_value !== want.popped)
                    begin
                        $display("%0t: popped_value expected %0d actual %0d",
                                 $time, want.popped, popped_value);
                        fail_count++;
                    end
                    if (current_min !== want.minimum)
                    begin
                        $display("%0t: current_min expected %0d actual %0d",
                                 $time, want.minimum, current_min);
                        fail_count++;
                    end
                    if (is_empty !== want.empty)
                    begin
                        $display("%0t: is_empty expected %0d actual %0d",
                                 $time, want.empty, is_empty);
                        fail_count++;
                    end
                    if (entry_count !== want.count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.count, entry_count);
                        fail_count++;
                    end
                    if (status !== want.code)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.code, status);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(step_stack(op, push_value));
        end
        pending = expected_q.size();
    end

endmodule

FILE: dv/min_tracking_stack_tb.sv
// min_tracking_stack_tb: drives push/pop commands into min_tracking_stack and
// reports the verdict. Depends on mts_pkg, the RTL and min_tracking_stack_checker.
`timescale 1ns / 1ps

module min_tracking_stack_tb;
    import mts_pkg::*;

    localparam int WIDTH = 32;
    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic signed [WIDTH-1:0] LARGEST  = {1'b0, {(WIDTH-1){1'b1}}};
    localparam logic signed [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       op;
    logic signed [WIDTH-1:0]    push_value;
    logic                       done;
    logic signed [WIDTH-1:0]    popped_value;
    logic signed [WIDTH-1:0]    current_min;
    logic                       is_empty;
    logic [$clog2(DEPTH+1)-1:0] entry_count;
    logic [1:0]                 status;
    int                         fail_count;
    int                         pending;
    int                         level;
    int                         cycle_count;
    bit                         idling;

    min_tracking_stack #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .push_value   (push_value),
        .done         (done),
        .popped_value (popped_value),
        .current_min  (current_min),
        .is_empty     (is_empty),
        .entry_count  (entry_count),
        .status       (status)
    );

    min_tracking_stack_checker #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .push_value   (push_value),
        .done         (done),
        .popped_value (popped_value),
        .current_min  (current_min),
        .is_empty     (is_empty),
        .entry_count  (entry_count),
        .status       (status),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // leans on a small range so duplicates and ties of the minimum are common
    function automatic logic signed [WIDTH-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return WIDTH'($urandom_range(0, 8) - 4);
        else if (sel == 4)
            return $urandom_range(0, 1) ? LARGEST : MOST_NEG;
        else
            return WIDTH'($urandom());
    endfunction

    task automatic issue_op(input logic o, input logic signed [WIDTH-1:0] v);
        while (idling && $urandom_range(0, 99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        op         <= o;
        push_value <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (o == OP_PUSH)
        begin
            if (level < DEPTH)
                level++;
        end
        else if (level > 0)
            level--;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_PUSH;
        push_value  = '0;
        level       = 0;
        cycle_count = 0;
        idling      = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_op(OP_POP, WIDTH'($urandom()));
        issue_op(OP_PUSH, '0);
        issue_op(OP_PUSH, LARGEST);
        issue_op(OP_PUSH, MOST_NEG);
        issue_op(OP_PUSH, MOST_NEG);
        issue_op(OP_PUSH, -1);
        issue_op(OP_PUSH, 5);
        repeat (6) issue_op(OP_POP, WIDTH'($urandom()));
        issue_op(OP_POP, '1);
        issue_op(OP_PUSH, LARGEST);
        issue_op(OP_PUSH, LARGEST);
        repeat (3) issue_op(OP_POP, '0);

        idling = 1'b1;
        while (level < DEPTH)
            issue_op(($urandom_range(0, 9) == 0) ? OP_POP : OP_PUSH, pick_value());
        repeat (5) issue_op(OP_PUSH, pick_value());

        idling = 1'b0;
        while (level > 0)
            issue_op(($urandom_range(0, 9) == 0) ? OP_PUSH : OP_POP, pick_value());
        repeat (4) issue_op(OP_POP, pick_value());

        idling = 1'b1;
        repeat (180) issue_op($urandom_range(0, 1) ? OP_POP : OP_PUSH, pick_value());
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
sv/mts_pkg.sv
sv/mts_ram.sv
sv/mts_ctrl.sv
sv/mts_datapath.sv
sv/min_tracking_stack.sv
sv/mts_checker.sv
dv/min_tracking_stack_checker.sv
dv/min_tracking_stack_tb.sv
